/* sv/udp_socket_demux_table_macros.svh */
// Assertion macros for the UDP socket demultiplexer table.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef UDP_SOCKET_DEMUX_TABLE_MACROS_SVH
`define UDP_SOCKET_DEMUX_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UDPSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define UDPSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/udpsd_pkg.sv */
// Shared types and codes for the UDP socket demultiplexer table.
// No dependencies.
package udpsd_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_DATAGRAM   = 2'd0;
	localparam logic [1:0] ACT_CONNECT    = 2'd1;
	localparam logic [1:0] ACT_LISTEN     = 2'd2;
	localparam logic [1:0] ACT_DISCONNECT = 2'd3;

	// result status codes
	localparam logic [2:0] ST_DELIVERED = 3'd0;
	localparam logic [2:0] ST_NO_MATCH  = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_OPENED    = 3'd4;
	localparam logic [2:0] ST_CLOSED    = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_LOCAL_IP       = 4'd0;
	localparam cfg_idx_t REG_FIRST_EPHEMERAL = 4'd1;

	localparam logic [15:0] UDP_HEADER_BYTES  = 16'd8;
	localparam logic [15:0] DEFAULT_EPHEMERAL = 16'd1024;

	// one row of the socket table memory
	typedef struct packed {
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [31:0] remote_ip;
		logic [31:0] local_ip;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOOKUP = 4'b0010,
		S_FREE   = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	// low four bits of a table index, as carried in the entry field
	function automatic logic [3:0] to_entry(input logic [7:0] idx);
		to_entry = idx[3:0];
	endfunction

endpackage

/* sv/udp_socket_demux_table.sv */
// UDP socket demultiplexer table: top level.
// Depends on udpsd_pkg and udp_socket_demux_table_macros.svh.
//
// Use:
//   Input channel (in_valid/in_ready) carries one item: an action with its
//   addresses, ports, IP length and slot. Output channel (out_valid/out_ready)
//   returns exactly one result item per input item: status, entry,
//   payload_length and assigned_port. Fields that do not apply are zero.
//   Configuration channel (cfg_valid/cfg_ready) writes local_ip (index 0) or
//   first_ephemeral_port (index 1, also reloads the port counter); other
//   indexes are ignored. Write it only while the block is idle.
// Timing:
//   One item is worked on at a time; in_ready is high only while idle.
//   Datagram lookup walks the table memory one entry per cycle through a
//   single compare unit, read data registered. Connect and listen walk the
//   valid bits for the lowest free slot. Short datagrams and disconnect go
//   straight to the result. The next item is accepted in the cycle after the
//   result moves to the output register.
// Reset and stall:
//   Reset clears all valid and listening bits and loads the port counter
//   with 1024; no clearing pass is needed. A stalled receiver holds the
//   result in the output register; the next item may still be accepted and
//   worked on, and its result waits until the output register frees.
`include "udp_socket_demux_table_macros.svh"

module udp_socket_demux_table #(
	parameter int SOCKETS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic [31:0]           peer_ip,
	input  logic [31:0]           own_ip,
	input  logic [15:0]           peer_port,
	input  logic [15:0]           own_port,
	input  logic [15:0]           ip_length,
	input  logic [3:0]            slot,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [3:0]            entry,
	output logic [15:0]           payload_length,
	output logic [15:0]           assigned_port,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  udpsd_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]           cfg_data
);
	import udpsd_pkg::*;

	localparam int IW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
	localparam int CW = $clog2(SOCKETS + 1);
	localparam logic [CW-1:0] CNT_N    = CW'(SOCKETS);
	localparam logic [IW-1:0] IDX_LAST = IW'(SOCKETS - 1);
	localparam logic [8:0]    SLOT_N   = 9'(SOCKETS);

	// configuration and counter
	logic [31:0] local_ip_q;
	logic [15:0] first_eph_q;
	logic [15:0] next_port_q;

	// per-entry flags in flip-flops, fields in memory
	logic [SOCKETS-1:0] entry_valid_q;
	logic [SOCKETS-1:0] entry_listening_q;
	entry_t             mem [SOCKETS];
	entry_t             rd_data_q;

	// held item
	logic [1:0]  action_q;
	logic [31:0] peer_ip_q;
	logic [31:0] own_ip_q;
	logic [15:0] peer_port_q;
	logic [15:0] own_port_q;
	logic [15:0] plen_q;

	// scan sequencer
	state_t        state_q;
	logic [CW-1:0] rd_idx_q;
	logic [IW-1:0] cmp_idx_q;
	logic          cmp_vld_q;

	// pending result and output register
	logic [2:0]  res_status_q;
	logic [3:0]  res_entry_q;
	logic [15:0] res_plen_q;
	logic [15:0] res_port_q;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [3:0]  out_entry_q;
	logic [15:0] out_plen_q;
	logic [15:0] out_port_q;

	logic          in_acc;
	logic          rd_en;
	logic          match_c;
	logic          hit_c;
	logic [IW-1:0] free_idx;
	logic          free_hit_c;
	logic          is_connect;
	logic [15:0]   open_port;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic [8:0]    slot_ext;
	logic [IW-1:0] slot_idx;
	logic          slot_ok;
	logic          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign entry          = out_entry_q;
	assign payload_length = out_plen_q;
	assign assigned_port  = out_port_q;

	// disconnect target: slot must lie inside the table and be open
	assign slot_ext = 9'(slot);
	assign slot_idx = slot_ext[IW-1:0];
	assign slot_ok  = (slot_ext < SLOT_N) && entry_valid_q[slot_idx];

	// the shared compare unit: one table row against the held datagram
	assign match_c = cmp_vld_q && entry_valid_q[cmp_idx_q]
		&& (rd_data_q.local_port == own_port_q) && (rd_data_q.local_ip == own_ip_q)
		&& (entry_listening_q[cmp_idx_q]
			|| ((rd_data_q.remote_port == peer_port_q) && (rd_data_q.remote_ip == peer_ip_q)));
	assign hit_c = (state_q == S_LOOKUP) && match_c;

	// lowest free slot search, one valid bit a cycle
	assign free_idx   = rd_idx_q[IW-1:0];
	assign free_hit_c = (state_q == S_FREE) && !entry_valid_q[free_idx];
	assign is_connect = (action_q == ACT_CONNECT);
	assign open_port  = is_connect ? next_port_q : own_port_q;

	assign rd_en = (state_q == S_LOOKUP) && (rd_idx_q < CNT_N);

	// single write port: bind a listener, or open a new row
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmp_idx_q;
		wr_data = rd_data_q;
		if (hit_c && entry_listening_q[cmp_idx_q]) begin
			wr_en               = 1'b1;
			wr_data.remote_port = peer_port_q;
			wr_data.remote_ip   = peer_ip_q;
		end
		if (free_hit_c) begin
			wr_en               = 1'b1;
			wr_addr             = free_idx;
			wr_data.local_port  = open_port;
			wr_data.remote_port = is_connect ? peer_port_q : 16'd0;
			wr_data.remote_ip   = is_connect ? peer_ip_q : 32'd0;
			wr_data.local_ip    = local_ip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx_q[IW-1:0]];
		end
	end

	// held item fields need no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q    <= action;
			peer_ip_q   <= peer_ip;
			own_ip_q    <= own_ip;
			peer_port_q <= peer_port;
			own_port_q  <= own_port;
			plen_q      <= ip_length - UDP_HEADER_BYTES;
		end
	end

	// configuration registers and port counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= 32'd0;
			first_eph_q <= DEFAULT_EPHEMERAL;
			next_port_q <= DEFAULT_EPHEMERAL;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOCAL_IP: begin
						local_ip_q <= cfg_data;
					end
					REG_FIRST_EPHEMERAL: begin
						first_eph_q <= cfg_data[15:0];
						next_port_q <= cfg_data[15:0];
					end
					default: begin
					end
				endcase
			end
			// advance the ephemeral port, wrap to the first one after the top
			if (free_hit_c && is_connect) begin
				next_port_q <= (next_port_q == 16'hFFFF) ? first_eph_q : next_port_q + 16'd1;
			end
		end
	end

	// sequencer and flag bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			rd_idx_q          <= '0;
			cmp_idx_q         <= '0;
			cmp_vld_q         <= 1'b0;
			entry_valid_q     <= '0;
			entry_listening_q <= '0;
			res_status_q      <= ST_NO_MATCH;
			res_entry_q       <= 4'd0;
			res_plen_q        <= 16'd0;
			res_port_q        <= 16'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rd_idx_q  <= '0;
					cmp_vld_q <= 1'b0;
					res_plen_q  <= 16'd0;
					res_port_q  <= 16'd0;
					// only a disconnect that closes a slot reports it from here
					if (in_acc && (action == ACT_DISCONNECT) && slot_ok) begin
						res_entry_q <= slot;
					end else begin
						res_entry_q <= 4'd0;
					end
					if (in_acc) begin
						case (action)
							ACT_DATAGRAM: begin
								if (ip_length < UDP_HEADER_BYTES) begin
									res_status_q <= ST_TOO_SHORT;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_LOOKUP;
								end
							end
							ACT_CONNECT, ACT_LISTEN: begin
								state_q <= S_FREE;
							end
							default: begin
								// disconnect: drop the slot if it is open
								if (slot_ok) begin
									entry_valid_q[slot_idx]     <= 1'b0;
									entry_listening_q[slot_idx] <= 1'b0;
									res_status_q <= ST_CLOSED;
								end else begin
									res_status_q <= ST_EMPTY;
								end
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_LOOKUP: begin
					// read the next row while comparing the previous one
					cmp_vld_q <= rd_en;
					cmp_idx_q <= rd_idx_q[IW-1:0];
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (match_c) begin
						entry_listening_q[cmp_idx_q] <= 1'b0;
						res_status_q <= ST_DELIVERED;
						res_entry_q  <= to_entry(8'(cmp_idx_q));
						res_plen_q   <= plen_q;
						state_q      <= S_RESP;
					end else if (cmp_vld_q && (cmp_idx_q == IDX_LAST)) begin
						res_status_q <= ST_NO_MATCH;
						state_q      <= S_RESP;
					end
				end
				S_FREE: begin
					if (free_hit_c) begin
						entry_valid_q[free_idx]     <= 1'b1;
						entry_listening_q[free_idx] <= !is_connect;
						res_status_q <= ST_OPENED;
						res_entry_q  <= to_entry(8'(free_idx));
						res_port_q   <= open_port;
						state_q      <= S_RESP;
					end else if (free_idx == IDX_LAST) begin
						res_status_q <= ST_FULL;
						state_q      <= S_RESP;
					end else begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
				end
				S_RESP: begin
					// hold until the output register frees
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			out_plen_q   <= res_plen_q;
			out_port_q   <= res_port_q;
		end
	end

	`UDPSD_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready,
		"item accepted while busy")
	`UDPSD_ASSERT(a_listen_implies_valid, (entry_listening_q & ~entry_valid_q) == '0,
		"listening bit on a free slot")
	`UDPSD_ASSERT(a_open_adds_one,
		free_hit_c |=> ($countones(entry_valid_q) == $past($countones(entry_valid_q)) + 1),
		"open did not add one entry")

endmodule

/* test/udp_socket_demux_table_check.sv */
// Checker for the UDP socket demultiplexer table: watches the three channels,
// predicts every result from its own copy of the socket table and compares.
// Depends on udpsd_pkg.
module udp_socket_demux_table_check #(
	parameter int SOCKETS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          action,
	input  logic [31:0]         peer_ip,
	input  logic [31:0]         own_ip,
	input  logic [15:0]         peer_port,
	input  logic [15:0]         own_port,
	input  logic [15:0]         ip_length,
	input  logic [3:0]          slot,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [2:0]          status,
	input  logic [3:0]          entry,
	input  logic [15:0]         payload_length,
	input  logic [15:0]         assigned_port,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  udpsd_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  fail_count,
	output int                  awaiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import udpsd_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  entry;
		logic [15:0] payload_length;
		logic [15:0] assigned_port;
	} socket_outcome_t;

	// shadow socket table and registers
	logic        sk_valid [SOCKETS];
	logic        sk_listen [SOCKETS];
	logic [15:0] sk_lport [SOCKETS];
	logic [15:0] sk_rport [SOCKETS];
	logic [31:0] sk_rip [SOCKETS];
	logic [31:0] sk_lip [SOCKETS];
	logic [15:0] port_counter;
	logic [15:0] first_port;
	logic [31:0] host_ip;

	socket_outcome_t due_results [$];
	int reported;

	// Apply one item to the shadow table and return the result it gives.
	function automatic socket_outcome_t resolve_item(input logic [1:0] act,
			input logic [31:0] pip, input logic [31:0] oip, input logic [15:0] pport,
			input logic [15:0] oport, input logic [15:0] len, input logic [3:0] sl);
		socket_outcome_t r;
		int i;
		int hit;
		logic [15:0] port;
		r = '0;
		hit = -1;
		case (act)
			ACT_DATAGRAM: begin
				if (len < UDP_HEADER_BYTES) begin
					r.status = ST_TOO_SHORT;
				end else begin
					for (i = 0; i < SOCKETS && hit < 0; i++) begin
						if (sk_valid[i] && sk_lport[i] == oport && sk_lip[i] == oip) begin
							if (sk_listen[i]) begin
								sk_listen[i] = 1'b0;
								sk_rport[i] = pport;
								sk_rip[i] = pip;
								hit = i;
							end else if (sk_rport[i] == pport && sk_rip[i] == pip) begin
								hit = i;
							end
						end
					end
					if (hit >= 0) begin
						r.status = ST_DELIVERED;
						r.entry = 4'(hit);
						r.payload_length = len - UDP_HEADER_BYTES;
					end else begin
						r.status = ST_NO_MATCH;
					end
				end
			end
			ACT_CONNECT, ACT_LISTEN: begin
				for (i = 0; i < SOCKETS && hit < 0; i++)
					if (!sk_valid[i])
						hit = i;
				if (hit < 0) begin
					r.status = ST_FULL;
				end else begin
					sk_valid[hit] = 1'b1;
					sk_lip[hit] = host_ip;
					if (act == ACT_CONNECT) begin
						port = port_counter;
						port_counter = (port_counter == 16'hFFFF) ? first_port
							: port_counter + 16'd1;
						sk_listen[hit] = 1'b0;
						sk_rip[hit] = pip;
						sk_rport[hit] = pport;
					end else begin
						port = oport;
						sk_listen[hit] = 1'b1;
						sk_rip[hit] = '0;
						sk_rport[hit] = '0;
					end
					sk_lport[hit] = port;
					r.status = ST_OPENED;
					r.entry = 4'(hit);
					r.assigned_port = port;
				end
			end
			default: begin
				if (int'(sl) >= SOCKETS || !sk_valid[sl]) begin
					r.status = ST_EMPTY;
				end else begin
					sk_valid[sl] = 1'b0;
					sk_listen[sl] = 1'b0;
					r.status = ST_CLOSED;
					r.entry = sl;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		socket_outcome_t want;
		int k;
		if (!arst_n) begin
			for (k = 0; k < SOCKETS; k++) begin
				sk_valid[k] = 1'b0;
				sk_listen[k] = 1'b0;
				sk_lport[k] = '0;
				sk_rport[k] = '0;
				sk_rip[k] = '0;
				sk_lip[k] = '0;
			end
			port_counter = DEFAULT_EPHEMERAL;
			first_port = DEFAULT_EPHEMERAL;
			host_ip = '0;
			due_results.delete();
			fail_count <= 0;
			awaiting <= 0;
			reported = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LOCAL_IP) begin
					host_ip = cfg_data;
				end else if (cfg_index == REG_FIRST_EPHEMERAL) begin
					first_port = cfg_data[15:0];
					port_counter = cfg_data[15:0];
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(resolve_item(action, peer_ip, own_ip, peer_port,
					own_port, ip_length, slot));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (reported < 10)
						$display("%0t: result with nothing expected:", $realtime,
							" st=%0d ent=%0d plen=%0d port=%0d",
							status, entry, payload_length, assigned_port);
					reported++;
				end else begin
					want = due_results.pop_front();
					if (want.status != status || want.entry != entry
							|| want.payload_length != payload_length
							|| want.assigned_port != assigned_port) begin
						fail_count <= fail_count + 1;
						if (reported < 10)
							$display("%0t: mismatch exp st=%0d ent=%0d plen=%0d port=%0d,",
								$realtime, want.status, want.entry,
								want.payload_length, want.assigned_port,
								" got st=%0d ent=%0d plen=%0d port=%0d",
								status, entry, payload_length, assigned_port);
						reported++;
					end
				end
			end
			awaiting <= due_results.size();
		end
	end

endmodule

/* test/udp_socket_demux_table_test.sv */
// Top of the UDP socket demultiplexer table testbench: clock, reset, stimulus
// and verdict. Depends on udpsd_pkg, udp_socket_demux_table and
// udp_socket_demux_table_check.
module udp_socket_demux_table_test;
	timeunit 1ns;
	timeprecision 1ps;
	import udpsd_pkg::*;

	localparam int TABLE_SLOTS = 16;
	localparam int PHASE_ITEMS = 155;
	localparam int PHASES = 6;
	// register indexes the block does not have; writes there must be ignored
	localparam cfg_idx_t REG_SPARE_LOW = 4'd2;
	localparam cfg_idx_t REG_SPARE_TOP = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_DATAGRAM;
	logic [31:0] peer_ip = '0;
	logic [31:0] own_ip = '0;
	logic [15:0] peer_port = '0;
	logic [15:0] own_port = '0;
	logic [15:0] ip_length = '0;
	logic [3:0]  slot = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [3:0]  entry;
	logic [15:0] payload_length;
	logic [15:0] assigned_port;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = REG_LOCAL_IP;
	logic [31:0] cfg_data = '0;

	int fail_count;
	int awaiting;

	// idling controls, set per phase; calm switches all idling off
	int  gap_chance = 3;
	int  stall_chance = 3;
	logic calm = 1'b0;
	int  stall_left = 0;

	// ports handed out lately, so that datagrams find open sockets
	logic [15:0] recent_ports [8];
	logic [2:0]  port_wr = '0;
	int          status_seen [8];

	udp_socket_demux_table #(.SOCKETS(TABLE_SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.peer_ip(peer_ip), .own_ip(own_ip), .peer_port(peer_port),
		.own_port(own_port), .ip_length(ip_length), .slot(slot),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.entry(entry), .payload_length(payload_length),
		.assigned_port(assigned_port),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	udp_socket_demux_table_check #(.SOCKETS(TABLE_SLOTS)) check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.peer_ip(peer_ip), .own_ip(own_ip), .peer_port(peer_port),
		.own_port(own_port), .ip_length(ip_length), .slot(slot),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.entry(entry), .payload_length(payload_length),
		.assigned_port(assigned_port),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .awaiting(awaiting)
	);

	always #5 clk = ~clk;

	// Receiver: take results, stall in short bursts, and remember every port
	// the block opens so later datagrams can aim at it.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			status_seen[status] <= status_seen[status] + 1;
			if (status == ST_OPENED) begin
				recent_ports[port_wr] <= assigned_port;
				port_wr <= port_wr + 3'd1;
			end
		end
		if (!arst_n || calm) begin
			out_ready <= arst_n;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 9) < stall_chance) begin
			stall_left <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one item and hold it until accepted. Returns just after the
	// accepting edge with valid still high, so the next item can follow at once.
	task automatic send_item(input logic [1:0] act, input logic [31:0] pip,
			input logic [31:0] oip, input logic [15:0] pport, input logic [15:0] oport,
			input logic [15:0] len, input logic [3:0] sl);
		if (!calm && $urandom_range(0, 9) < gap_chance) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		peer_ip <= pip;
		own_ip <= oip;
		peer_port <= pport;
		own_port <= oport;
		ip_length <= len;
		slot <= sl;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold a register write until accepted; the caller drops cfg_valid.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		logic [31:0] peer_ip_pool [4];
		logic [15:0] peer_port_pool [4];
		logic [15:0] listen_pool [4];
		logic [31:0] host_ip;
		logic [15:0] eph;
		logic [1:0]  act;
		logic [31:0] pip, oip;
		logic [15:0] pport, oport, len;
		logic [3:0]  sl;
		int ph, n, r, w_dg, w_cn, w_ls;
		int items, writes;

		peer_ip_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
		peer_port_pool = '{16'h0, 16'hFFFF, 16'($urandom), 16'($urandom)};
		listen_pool = '{16'h0, 16'hFFFF, 16'd80, 16'($urandom)};
		for (n = 0; n < 8; n++)
			recent_ports[n] = listen_pool[n % 4];
		for (n = 0; n < 8; n++)
			status_seen[n] = 0;
		items = 0;
		writes = 0;
		host_ip = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset register values (host IP 0, ports from 1024).
		// Short datagrams, then a lookup into an empty table.
		send_item(ACT_DATAGRAM, 32'h0, 32'h0, 16'h0, 16'h0, 16'd0, 4'd0);
		send_item(ACT_DATAGRAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd7, 4'hF);
		send_item(ACT_DATAGRAM, 32'h0, 32'h0, 16'h0, 16'h0, 16'd8, 4'd0);
		// closing slots that were never opened
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0);
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'hF);
		// open two listeners at the port extremes and two connections
		send_item(ACT_LISTEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'h0, 4'd0);
		send_item(ACT_LISTEN, 32'h0, 32'h0, 16'h0, 16'hFFFF, 16'h0, 4'd0);
		send_item(ACT_CONNECT, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'h0, 4'd0);
		send_item(ACT_CONNECT, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'hFFFF, 4'hF);
		// first datagram binds the listener; the same sender then matches, others not
		send_item(ACT_DATAGRAM, peer_ip_pool[2], 32'h0, peer_port_pool[2], 16'h0, 16'd8, 4'd0);
		send_item(ACT_DATAGRAM, peer_ip_pool[2], 32'h0, peer_port_pool[2], 16'h0, 16'hFFFF,
			4'd0);
		send_item(ACT_DATAGRAM, peer_ip_pool[3], 32'h0, peer_port_pool[2], 16'h0, 16'd100,
			4'd0);
		// four-tuple of the connected entries: exact, port off by one, wrong own IP
		send_item(ACT_DATAGRAM, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, DEFAULT_EPHEMERAL, 16'd64, 4'd0);
		send_item(ACT_DATAGRAM, 32'hFFFF_FFFF, 32'h0, 16'hFFFE, DEFAULT_EPHEMERAL, 16'd64, 4'd0);
		send_item(ACT_DATAGRAM, 32'h0, 32'h1, 16'h0, DEFAULT_EPHEMERAL + 16'd1, 16'd64, 4'd0);
		send_item(ACT_DATAGRAM, 32'h0, 32'h0, 16'h0, DEFAULT_EPHEMERAL + 16'd1, 16'd9, 4'd0);
		// bind the second listener, close it, and check it no longer answers
		send_item(ACT_DATAGRAM, 32'h1234_5678, 32'h0, 16'd53, 16'hFFFF, 16'd20, 4'd0);
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'd1);
		send_item(ACT_DATAGRAM, 32'h1234_5678, 32'h0, 16'd53, 16'hFFFF, 16'd20, 4'd0);
		// listen again takes the lowest freed slot; then empty the table
		send_item(ACT_LISTEN, 32'h0, 32'h0, 16'h0, 16'd80, 16'h0, 4'd0);
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0);
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'd2);
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'd3);
		send_item(ACT_DISCONNECT, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 4'd1);
		items += 24;

		for (ph = 0; ph < PHASES; ph++) begin
			// drain before touching the registers
			in_valid <= 1'b0;
			do @(posedge clk); while (awaiting != 0);

			w_dg = 55;
			w_cn = 15;
			w_ls = 10;
			gap_chance = 3;
			stall_chance = 3;
			case (ph)
				0: begin
					// open-heavy so the table fills; counter wraps after two ports
					host_ip = $urandom;
					eph = 16'hFFFE;
					w_dg = 30;
					w_cn = 35;
					w_ls = 25;
					write_reg(REG_SPARE_LOW, $urandom);
					writes++;
				end
				1: begin
					host_ip = 32'hFFFF_FFFF;
					eph = 16'd1;
					gap_chance = 5;
					stall_chance = 0;
				end
				2: begin
					// every connect gets the same top port
					host_ip = 32'h0;
					eph = 16'hFFFF;
					w_dg = 50;
					w_cn = 20;
					gap_chance = 0;
					stall_chance = 5;
					write_reg(REG_SPARE_TOP, $urandom);
					writes++;
				end
				3: begin
					// zero is out of range but used as given
					host_ip = $urandom;
					eph = 16'h0;
				end
				4: begin
					host_ip = $urandom;
					eph = 16'($urandom_range(1, 65535));
					w_dg = 45;
					w_cn = 20;
					w_ls = 15;
					gap_chance = 4;
					stall_chance = 4;
				end
				default: begin
					// last stretch runs flat out
					host_ip = $urandom;
					eph = DEFAULT_EPHEMERAL;
					calm = 1'b1;
				end
			endcase
			write_reg(REG_LOCAL_IP, host_ip);
			write_reg(REG_FIRST_EPHEMERAL, {16'($urandom), eph});
			writes += 2;
			cfg_valid <= 1'b0;

			for (n = 0; n < PHASE_ITEMS; n++) begin
				pip = $urandom;
				oip = $urandom;
				pport = 16'($urandom);
				oport = 16'($urandom);
				len = 16'($urandom);
				sl = 4'($urandom);
				r = $urandom_range(0, 99);
				if (r < w_dg) begin
					act = ACT_DATAGRAM;
					// mostly aim at open sockets from known senders; the rest is noise
					if ($urandom_range(0, 99) < 85) begin
						oip = host_ip;
						oport = recent_ports[$urandom_range(0, 7)];
						pip = peer_ip_pool[$urandom_range(0, 3)];
						pport = peer_port_pool[$urandom_range(0, 3)];
						case ($urandom_range(0, 9))
							0: len = 16'($urandom_range(0, 7));
							1: len = 16'hFFFF;
							default: len = 16'($urandom_range(8, 1500));
						endcase
					end
				end else if (r < w_dg + w_cn) begin
					act = ACT_CONNECT;
					if ($urandom_range(0, 99) < 85) begin
						pip = peer_ip_pool[$urandom_range(0, 3)];
						pport = peer_port_pool[$urandom_range(0, 3)];
					end
				end else if (r < w_dg + w_cn + w_ls) begin
					act = ACT_LISTEN;
					if ($urandom_range(0, 99) < 70)
						oport = listen_pool[$urandom_range(0, 3)];
				end else begin
					act = ACT_DISCONNECT;
				end
				send_item(act, pip, oip, pport, oport, len, sl);
				items++;
			end
		end
		in_valid <= 1'b0;

		// drain, then allow a table scan's worth of cycles for stray results
		do @(posedge clk); while (awaiting != 0);
		repeat (2 * TABLE_SLOTS + 4) @(posedge clk);

		$display("run covered %0d items over %0d register settings, %0d register writes",
			items, PHASES + 1, writes);
		$display("delivered %0d, no match %0d, too short %0d, full %0d, opened %0d, closed %0d, empty slot %0d",
			status_seen[ST_DELIVERED], status_seen[ST_NO_MATCH], status_seen[ST_TOO_SHORT],
			status_seen[ST_FULL], status_seen[ST_OPENED], status_seen[ST_CLOSED],
			status_seen[ST_EMPTY]);
		if (fail_count == 0 && awaiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog: several times the slowest correct run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
